### rtl/kncm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kncm_pkg
// Shared sizes, types and helpers of the known network change monitor.
// ----------------------------------------------------------------------------
package kncm_pkg;

  // table and scan sizes
  localparam int unsigned KNOWN_ENTRIES = 32;
  localparam int unsigned SCAN_ENTRIES  = 32;

  // field widths
  localparam int unsigned ID_W      = 48;
  localparam int unsigned TOTAL_W   = 6;
  localparam int unsigned TOTAL_MAX = 63;
  localparam int unsigned MASK_W    = 32;

  // derived widths
  localparam int unsigned IDX_W   = (KNOWN_ENTRIES > 1) ? $clog2(KNOWN_ENTRIES) : 1;
  localparam int unsigned USED_W  = $clog2(KNOWN_ENTRIES + 1);
  localparam int unsigned TAKEN_W = $clog2(SCAN_ENTRIES + 1);
  localparam int unsigned CNT_A   = (USED_W > TAKEN_W) ? USED_W : TAKEN_W;
  localparam int unsigned CNT_W   = (CNT_A > TOTAL_W) ? CNT_A : TOTAL_W + 1;
  localparam int unsigned MASK_N  = (KNOWN_ENTRIES < MASK_W) ? KNOWN_ENTRIES : MASK_W;

  // result beat layout, payload width padded to whole bytes
  localparam int unsigned RES_W  = 4 + 2 * TOTAL_W + MASK_W + 2;
  localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

  // access to the known table memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } kncm_mem_req_t;

  // one result, first member in the highest bits (is_new lands in bit 0)
  typedef struct packed {
    logic               baseline_taken;
    logic               any_change;
    logic [MASK_W-1:0]  missing_mask;
    logic [TOTAL_W-1:0] missing_total;
    logic [TOTAL_W-1:0] new_total;
    logic               scan_done;
    logic               dropped;
    logic               stored_as_baseline;
    logic               is_new;
  } kncm_result_t;

  // clamp a count to the reported width
  function automatic logic [TOTAL_W-1:0] sat_total(input logic [CNT_W-1:0] v);
    logic [TOTAL_W-1:0] r;
    if (v > CNT_W'(TOTAL_MAX)) begin
      r = TOTAL_W'(TOTAL_MAX);
    end else begin
      r = v[TOTAL_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/kncm_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kncm_table
// Known BSSID table: one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module kncm_table (
  input  logic                          clk_i,
  input  kncm_pkg::kncm_mem_req_t       req_i,
  output logic [kncm_pkg::ID_W-1:0]     rdata_o
);
  import kncm_pkg::*;

  logic [ID_W-1:0] mem [KNOWN_ENTRIES];
  logic [ID_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, read data registered on the read enable
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kncm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kncm_ctrl
// Scan sequencer: baseline fill, table walk per entry, end of scan summary.
// ----------------------------------------------------------------------------
module kncm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item in
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_has_i,
  input  logic [kncm_pkg::ID_W-1:0]     in_id_i,
  input  logic                          in_last_i,
  // table port
  output kncm_pkg::kncm_mem_req_t       mem_req_o,
  input  logic [kncm_pkg::ID_W-1:0]     mem_rdata_i,
  // result out
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output kncm_pkg::kncm_result_t        res_o
);
  import kncm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SUM,
    ST_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [USED_W-1:0]      used_q, used_d;
  logic [KNOWN_ENTRIES-1:0] seen_q, seen_d;
  logic [TAKEN_W-1:0]     new_q, new_d;
  logic [TAKEN_W-1:0]     taken_q, taken_d;
  logic                   base_q, base_d;
  logic                   mid_q, mid_d;
  logic                   last_q, last_d;
  logic [ID_W-1:0]        id_q, id_d;
  logic [USED_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;
  logic                   pend_q, pend_d;
  logic                   hit_q, hit_d;
  logic [USED_W-1:0]      cnt_q, cnt_d;
  logic [KNOWN_ENTRIES-1:0] miss_q, miss_d;
  kncm_result_t           res_q, res_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // next state and datapath
  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    seen_d    = seen_q;
    new_d     = new_q;
    taken_d   = taken_q;
    base_d    = base_q;
    mid_d     = mid_q;
    last_d    = last_q;
    id_d      = id_q;
    idx_d     = idx_q;
    pidx_d    = pidx_q;
    pend_d    = pend_q;
    hit_d     = hit_q;
    cnt_d     = cnt_q;
    miss_d    = miss_q;
    res_d     = res_q;
    mem_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d  = '0;
          last_d = in_last_i;
          id_d   = in_id_i;
          idx_d  = '0;
          pend_d = 1'b0;
          hit_d  = 1'b0;
          cnt_d  = '0;
          miss_d = '0;
          if (in_has_i || in_last_i) begin
            mid_d = 1'b1;
            // first beat of a scan
            if (!mid_q) begin
              base_d  = (used_q == '0);
              seen_d  = '0;
              new_d   = '0;
              taken_d = '0;
            end
            if (in_has_i) begin
              if (taken_d >= TAKEN_W'(SCAN_ENTRIES)) begin
                res_d.dropped = 1'b1;
                state_d = in_last_i ? ST_SUM : ST_DONE;
              end else begin
                taken_d = taken_d + 1'b1;
                if (base_d) begin
                  // baseline fill while room is left
                  if (used_q < USED_W'(KNOWN_ENTRIES)) begin
                    mem_req_o.we    = 1'b1;
                    mem_req_o.waddr = used_q[IDX_W-1:0];
                    mem_req_o.wdata = in_id_i;
                    used_d = used_q + 1'b1;
                    res_d.stored_as_baseline = 1'b1;
                  end
                  state_d = in_last_i ? ST_SUM : ST_DONE;
                end else begin
                  state_d = ST_LOOK;
                end
              end
            end else begin
              state_d = ST_SUM;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_LOOK: begin
        // compare the slot read in the previous cycle
        if (pend_q && (mem_rdata_i == id_q)) begin
          hit_d = 1'b1;
          seen_d[pidx_q] = 1'b1;
        end
        if (idx_q < used_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_q[IDX_W-1:0];
          pidx_d = idx_q[IDX_W-1:0];
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          if (!hit_q) begin
            res_d.is_new = 1'b1;
            new_d = new_q + 1'b1;
          end
          idx_d   = '0;
          state_d = last_q ? ST_SUM : ST_DONE;
        end
      end

      ST_SUM: begin
        if (base_q) begin
          res_d.scan_done      = 1'b1;
          res_d.baseline_taken = 1'b1;
          mid_d   = 1'b0;
          base_d  = 1'b0;
          seen_d  = '0;
          new_d   = '0;
          taken_d = '0;
          state_d = ST_DONE;
        end else if (idx_q < used_q) begin
          // one known slot per cycle
          if (!seen_q[idx_q[IDX_W-1:0]]) begin
            miss_d[idx_q[IDX_W-1:0]] = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end else begin
          res_d.scan_done     = 1'b1;
          res_d.new_total     = sat_total(CNT_W'(new_q));
          res_d.missing_total = sat_total(CNT_W'(cnt_q));
          for (int j = 0; j < MASK_N; j++) begin
            res_d.missing_mask[j] = miss_q[j];
          end
          res_d.any_change = (new_q != '0) || (cnt_q != '0);
          mid_d   = 1'b0;
          base_d  = 1'b0;
          seen_d  = '0;
          new_d   = '0;
          taken_d = '0;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      seen_q  <= '0;
      new_q   <= '0;
      taken_q <= '0;
      base_q  <= 1'b0;
      mid_q   <= 1'b0;
      last_q  <= 1'b0;
      id_q    <= '0;
      idx_q   <= '0;
      pidx_q  <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      cnt_q   <= '0;
      miss_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      seen_q  <= seen_d;
      new_q   <= new_d;
      taken_q <= taken_d;
      base_q  <= base_d;
      mid_q   <= mid_d;
      last_q  <= last_d;
      id_q    <= id_d;
      idx_q   <= idx_d;
      pidx_q  <= pidx_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      cnt_q   <= cnt_d;
      miss_q  <= miss_d;
      res_q   <= res_d;
    end
  end

endmodule

### rtl/known_network_change_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// known_network_change_monitor
// Tracks known BSSIDs and reports new and missing access points per scan.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one scanned access point per beat: tdata = BSSID,
//   tuser = has_entry (0 for a bare end marker), tlast = last beat of a scan.
//   m_axis returns exactly one result beat for every accepted input beat.
//   The first scan seen with an empty table is stored as the baseline; later
//   scans are looked up against it and summarized on their last beat.
// Timing:
//   a baseline, dropped or bare beat makes no table lookup;
//   a lookup walks the table memory one slot a cycle;
//   a scan end adds a summary walk over the slots in use (none on a baseline scan).
//   With a full 32 entry table, the single read port of the table memory sets
//   the pace of each looked up beat.
//   One beat is in work at a time; the next is taken once its result has moved
//   into the output register.
// Reset: clears the table fill count and all scan state; the table contents
//   are only read below the fill count.
// Stall: a held result sits in the output register; the sequencer can finish
//   one more beat behind it and then holds s_axis_tready low.
// ----------------------------------------------------------------------------
module known_network_change_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // scan beats in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [kncm_pkg::ID_W-1:0]        s_axis_tdata,  // [47:0] station_id
  input  logic                             s_axis_tuser,  // [0] has_entry
  input  logic                             s_axis_tlast,  // scan_end
  // result beats out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] is_new, [1] stored_as_baseline, [2] dropped, [3] scan_done,
  // [9:4] new_total, [15:10] missing_total, [47:16] missing_mask,
  // [48] any_change, [49] baseline_taken, [55:50] zero
  output logic [kncm_pkg::TDATA_W-1:0]     m_axis_tdata
);
  import kncm_pkg::*;

  kncm_mem_req_t  mem_req;
  logic [ID_W-1:0] mem_rdata;
  logic           res_valid;
  logic           res_ready;
  kncm_result_t   res;

  logic           out_valid_q, out_valid_d;
  kncm_result_t   out_res_q, out_res_d;

  kncm_table u_table (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  kncm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_has_i    (s_axis_tuser),
    .in_id_i     (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register, refilled as soon as the held beat leaves
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_res_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(TDATA_W - RES_W)'(0), out_res_q};

endmodule
